### design/gldf_pkg.sv
// Package: constants, result codes and CRC step function for the log frame deframer.
package gldf_pkg;

  localparam logic [7:0]  SYNC_A       = 8'hAA;
  localparam logic [7:0]  SYNC_B       = 8'h44;
  localparam logic [7:0]  SYNC_C       = 8'h12;
  localparam int unsigned HeaderBytes  = 28;
  localparam int unsigned TrailerBytes = 4;
  localparam logic [31:0] POLY_RESET   = 32'hEDB88320;

  // Header byte offsets of the captured fields (little-endian).
  localparam logic [15:0] OFS_ID_LO   = 16'd4;
  localparam logic [15:0] OFS_ID_HI   = 16'd5;
  localparam logic [15:0] OFS_LEN_LO  = 16'd8;
  localparam logic [15:0] OFS_LEN_HI  = 16'd9;
  localparam logic [15:0] OFS_WEEK_LO = 16'd14;
  localparam logic [15:0] OFS_WEEK_HI = 16'd15;
  localparam logic [15:0] OFS_MS_0    = 16'd16;
  localparam logic [15:0] OFS_MS_1    = 16'd17;
  localparam logic [15:0] OFS_MS_2    = 16'd18;
  localparam logic [15:0] OFS_MS_3    = 16'd19;
  localparam logic [15:0] OFS_HDR_END = 16'(HeaderBytes - 1);

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_t;

  // One byte of a reflected CRC, LSB first, eight shift/xor steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data,
                                           input logic [31:0] poly);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### design/gldf_if.sv
// Interfaces: byte input channel, result channel and polynomial write channel.
interface gldf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface gldf_result_if
  import gldf_pkg::*;
;
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;
  logic [15:0] message_id;
  logic [15:0] payload_len;
  logic [15:0] gps_week;
  logic [31:0] week_ms;
  logic        frame_last;

  modport source (output valid, output kind, output data_byte, output byte_index,
                  output message_id, output payload_len, output gps_week,
                  output week_ms, output frame_last, input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_index,
                  input message_id, input payload_len, input gps_week,
                  input week_ms, input frame_last, output ready);
endinterface

interface gldf_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_polynomial;

  modport source (output valid, output crc_polynomial, input ready);
  modport sink   (input valid, input crc_polynomial, output ready);
endinterface

### design/gnss_log_frame_deframer.sv
// Top level: receiver log frame deframer with sync hunt, header capture and 32-bit CRC check.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-------------------------------------------
//   in_ch   | in  | valid/ready          | in_byte
//   out_ch  | out | valid/ready          | kind, data_byte, byte_index, message_id,
//           |     |                      | payload_len, gps_week, week_ms, frame_last
//   cfg_ch  | in  | valid/ready (always) | crc_polynomial
//
// One byte is taken per cycle while in_ch.ready is high; its result, if any, shows on
// out_ch the next cycle from the output register. The rate is set by one eight-step
// CRC byte update per cycle. After reset, and after each polynomial write, in_ch.ready
// stays low while the CRC of the sync word is recomputed with the current polynomial
// (one sync byte per cycle). A stalled result blocks new bytes only when out_ch.ready
// is low. rst_n is synchronous, active low.
module gnss_log_frame_deframer
  import gldf_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  gldf_byte_if.sink      in_ch,
  gldf_result_if.source  out_ch,
  gldf_cfg_if.sink       cfg_ch
);

  typedef enum logic [2:0] {
    PH_HUNT0,
    PH_HUNT1,
    PH_HUNT2,
    PH_HEADER,
    PH_PAYLOAD,
    PH_CHECK
  } phase_t;

  // Sync word CRC preset: steps remaining, 0 when the preset is valid.
  localparam logic [1:0] PRE_DONE = 2'd0;
  localparam logic [1:0] PRE_B    = 2'd2;
  localparam logic [1:0] PRE_A    = 2'd3;

  logic [31:0] poly_r;
  logic [1:0]  pre_cnt_r;
  logic [31:0] sync_crc_r;

  phase_t      phase_r,  phase_nxt;
  logic [15:0] pos_r,    pos_nxt;
  logic [31:0] crc_r,    crc_nxt;
  logic [15:0] id_r,     id_nxt;
  logic [15:0] len_r,    len_nxt;
  logic [15:0] week_r,   week_nxt;
  logic [31:0] ms_r,     ms_nxt;
  logic [23:0] chk_r,    chk_nxt;

  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [7:0]  out_data_r;
  logic [15:0] out_index_r;
  logic [15:0] out_id_r;
  logic [15:0] out_len_r;
  logic [15:0] out_week_r;
  logic [31:0] out_ms_r;
  logic        out_last_r;

  logic        emit_c;
  kind_t       emit_kind_c;
  logic [7:0]  emit_data_c;
  logic [15:0] emit_index_c;
  logic        emit_last_c;

  logic        in_acc;
  logic [7:0]  b;
  logic [31:0] crc_step;
  logic [16:0] pos_inc;
  logic [7:0]  pre_byte;
  logic [31:0] pre_src;

  // Accept a byte only with a valid sync preset and room in the output register.
  assign in_ch.ready = (pre_cnt_r == PRE_DONE) && (!out_valid_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign b        = in_ch.in_byte;
  assign crc_step = crc_byte(crc_r, b, poly_r);
  assign pos_inc  = {1'b0, pos_r} + 17'd1;

  // ---------------------------------------------------------------------------
  // Polynomial register and sync word CRC preset
  // ---------------------------------------------------------------------------
  always_comb begin
    pre_byte = (pre_cnt_r == PRE_A) ? SYNC_A : ((pre_cnt_r == PRE_B) ? SYNC_B : SYNC_C);
    pre_src  = (pre_cnt_r == PRE_A) ? 32'd0 : sync_crc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r    <= POLY_RESET;
      pre_cnt_r <= PRE_A;
    end else if (cfg_ch.valid) begin
      // Restart the preset on any write, even one mid-recompute.
      poly_r    <= cfg_ch.crc_polynomial;
      pre_cnt_r <= PRE_A;
    end else if (pre_cnt_r != PRE_DONE) begin
      pre_cnt_r <= pre_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pre_cnt_r != PRE_DONE) begin
      sync_crc_r <= crc_byte(pre_src, pre_byte, poly_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Frame phase logic
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    id_nxt       = id_r;
    len_nxt      = len_r;
    week_nxt     = week_r;
    ms_nxt       = ms_r;
    chk_nxt      = chk_r;
    emit_c       = 1'b0;
    emit_kind_c  = KIND_PAYLOAD;
    emit_data_c  = 8'd0;
    emit_index_c = 16'd0;
    emit_last_c  = 1'b0;

    unique case (phase_r)
      PH_HUNT0: begin
        phase_nxt = (b == SYNC_A) ? PH_HUNT1 : PH_HUNT0;
      end
      PH_HUNT1: begin
        // Repeated AA keeps the hunt here: overlapping sync.
        if (b == SYNC_B) begin
          phase_nxt = PH_HUNT2;
        end else if (b != SYNC_A) begin
          phase_nxt = PH_HUNT0;
        end
      end
      PH_HUNT2: begin
        if (b == SYNC_C) begin
          crc_nxt   = sync_crc_r;
          pos_nxt   = 16'd3;
          phase_nxt = PH_HEADER;
        end else begin
          phase_nxt = (b == SYNC_A) ? PH_HUNT1 : PH_HUNT0;
        end
      end
      PH_HEADER: begin
        crc_nxt = crc_step;
        unique case (pos_r)
          OFS_ID_LO:   id_nxt   = {8'd0, b};
          OFS_ID_HI:   id_nxt   = {b, id_r[7:0]};
          OFS_LEN_LO:  len_nxt  = {8'd0, b};
          OFS_LEN_HI:  len_nxt  = {b, len_r[7:0]};
          OFS_WEEK_LO: week_nxt = {8'd0, b};
          OFS_WEEK_HI: week_nxt = {b, week_r[7:0]};
          OFS_MS_0:    ms_nxt   = {24'd0, b};
          OFS_MS_1:    ms_nxt   = {16'd0, b, ms_r[7:0]};
          OFS_MS_2:    ms_nxt   = {8'd0, b, ms_r[15:0]};
          OFS_MS_3:    ms_nxt   = {b, ms_r[23:0]};
          default:     ;
        endcase
        if (pos_r == OFS_HDR_END) begin
          pos_nxt   = 16'd0;
          // Empty payload goes straight to the trailer.
          phase_nxt = (len_r == 16'd0) ? PH_CHECK : PH_PAYLOAD;
        end else begin
          pos_nxt = pos_inc[15:0];
        end
      end
      PH_PAYLOAD: begin
        crc_nxt      = crc_step;
        emit_c       = 1'b1;
        emit_data_c  = b;
        emit_index_c = pos_r;
        if (pos_inc >= {1'b0, len_r}) begin
          pos_nxt   = 16'd0;
          phase_nxt = PH_CHECK;
        end else begin
          pos_nxt = pos_inc[15:0];
        end
      end
      PH_CHECK: begin
        unique case (pos_r[1:0])
          2'd0: chk_nxt = {16'd0, b};
          2'd1: chk_nxt = {8'd0, b, chk_r[7:0]};
          2'd2: chk_nxt = {b, chk_r[15:0]};
          2'd3: begin
            // Last trailer byte: compare and report, then resume the hunt.
            emit_c      = 1'b1;
            emit_kind_c = ({b, chk_r} == crc_r) ? KIND_GOOD : KIND_BAD;
            emit_last_c = 1'b1;
          end
        endcase
        if (pos_r[1:0] == 2'(TrailerBytes - 1)) begin
          pos_nxt   = 16'd0;
          phase_nxt = PH_HUNT0;
        end else begin
          pos_nxt = {14'd0, pos_inc[1:0]};
        end
      end
      default: begin
        phase_nxt = PH_HUNT0;
        pos_nxt   = 16'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT0;
      pos_r   <= 16'd0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Header fields and CRC are rewritten in each frame before any result uses them.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      crc_r  <= crc_nxt;
      id_r   <= id_nxt;
      len_r  <= len_nxt;
      week_r <= week_nxt;
      ms_r   <= ms_nxt;
      chk_r  <= chk_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= emit_c;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Header fields come from the registered state before this byte; that is safe as the
  // last header byte never produces a result.
  always_ff @(posedge clk) begin
    if (in_acc && emit_c) begin
      out_kind_r  <= emit_kind_c;
      out_data_r  <= emit_data_c;
      out_index_r <= emit_index_c;
      out_id_r    <= id_r;
      out_len_r   <= len_r;
      out_week_r  <= week_r;
      out_ms_r    <= ms_r;
      out_last_r  <= emit_last_c;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = out_kind_r;
  assign out_ch.data_byte      = out_data_r;
  assign out_ch.byte_index     = out_index_r;
  assign out_ch.message_id     = out_id_r;
  assign out_ch.payload_len    = out_len_r;
  assign out_ch.gps_week       = out_week_r;
  assign out_ch.week_ms        = out_ms_r;
  assign out_ch.frame_last     = out_last_r;

endmodule
